FILE: hw/rtl/smma_pkg.sv
// shared types, command and register codes for the scaled matrix multiply-accumulate
// no dependencies; imported by smma_mac_pipe, the top level and smma_checker
`timescale 1ns / 1ps
`default_nettype none

package smma_pkg;

	localparam int A_W    = 16;
	localparam int C_W    = 32;
	localparam int PROD_W = 48;
	localparam int SUM_W  = 41;

	typedef enum logic [2:0] {
		CMD_WRITE_A = 3'd0,
		CMD_WRITE_B = 3'd1,
		CMD_WRITE_C = 3'd2,
		CMD_COMPUTE = 3'd3,
		CMD_READ_C  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		REG_ROWS_M  = 3'd0,
		REG_COLS_N  = 3'd1,
		REG_INNER_K = 3'd2,
		REG_ALPHA   = 3'd3,
		REG_BETA    = 3'd4
	} reg_idx_t;

	// tag that travels with one operation through the multiply pipe
	typedef struct packed {
		logic valid;
		logic init;
		logic last;
	} smma_op_t;

	// write-back and occupancy seen by the sequencer
	typedef struct packed {
		logic                  we;
		logic                  busy;
		logic signed [C_W-1:0] data;
	} smma_wb_t;

	function automatic logic signed [C_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
		if (x > 41'sh007fffffff) return 32'sh7fffffff;
		if (x < -41'sh0080000000) return -32'sh80000000;
		return x[C_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/scaled_matrix_multiply_accumulate.sv
// top level of the fixed-point scaled matrix multiply-accumulate, C = beta*C + alpha*A*B
// depends on smma_pkg and smma_mac_pipe; A, B and C live in local synchronous memories
`timescale 1ns / 1ps
`default_nettype none

// Each beat on start/command/row/col/value is accepted when start is high and busy is
// low, and gives exactly one result: done is high for one cycle with status and
// read_value, and the receiver cannot hold it off. For writes of A, B or C and reads
// of C the result shows in the cycle after acceptance and busy stays low, so these
// beats may follow one per cycle. A compute beat holds busy high until the pipe has
// drained, and its result shows as busy falls, with M, N and K the configured sizes
// after clamping to 1..MAX_DIM. The sequencer issues one memory read per cycle into
// a single multiply pipe: one slot for the beta term per C entry and one per
// inner-loop step, plus the pipe drain. An index outside the configured size, or an
// unknown command, returns status 1 and changes nothing. Configuration is written on
// cfg_write, and the user must do so only while idle; the block does not enforce it.
module scaled_matrix_multiply_accumulate
	import smma_pkg::*;
#(
	parameter int MAX_DIM = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [15:0]           cfg_data,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [2:0]            command,
	input  wire logic [3:0]            row,
	input  wire logic [3:0]            col,
	input  wire logic signed [31:0]    value,
	output logic                       done,
	output logic                       status,
	output logic signed [31:0]         read_value
);

	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CNT_W  = IDX_W + 1;
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_RUN   = 3'b010,
		S_DRAIN = 3'b100
	} state_t;

	// dimension register, zero acts as one, clamp at MAX_DIM
	function automatic logic [CNT_W-1:0] dim_of(input logic [4:0] r);
		if (r == 5'd0) return CNT_W'(1);
		if (int'(r) > MAX_DIM) return CNT_W'(MAX_DIM);
		return CNT_W'(r);
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		return ADDR_W'(32'(r) * MAX_DIM + 32'(c));
	endfunction

	function automatic logic below(input logic [3:0] idx, input logic [CNT_W-1:0] lim);
		return 32'(idx) < 32'(lim);
	endfunction

	// configuration registers
	logic [4:0]             rows_m_q, cols_n_q, inner_k_q;
	logic signed [A_W-1:0]  alpha_q, beta_q;

	// sequencer
	state_t                 state_q;
	logic [IDX_W-1:0]       m_q, n_q, k_q;
	logic                   init_q;
	smma_op_t               op_s1;
	logic [ADDR_W-1:0]      caddr_s1, caddr_s2, caddr_s3;

	// result register
	logic                   done_q, status_q, rdsel_q;

	// memories and their registered read data
	logic signed [A_W-1:0]  a_mem [DEPTH];
	logic signed [A_W-1:0]  b_mem [DEPTH];
	logic signed [C_W-1:0]  c_mem [DEPTH];
	logic signed [A_W-1:0]  a_s1, b_s1;
	logic signed [C_W-1:0]  c_s1;

	logic [CNT_W-1:0]       m_dim, n_dim, k_dim;
	logic                   accept;
	logic                   item_ok;
	logic [ADDR_W-1:0]      item_addr;
	logic                   a_we, b_we, c_item_we;
	logic                   c_we;
	logic [ADDR_W-1:0]      c_waddr, c_raddr;
	logic signed [C_W-1:0]  c_wdata;
	logic                   k_last, n_last, m_last;
	logic                   drain_end;
	smma_wb_t               wb;

	assign m_dim = dim_of(rows_m_q);
	assign n_dim = dim_of(cols_n_q);
	assign k_dim = dim_of(inner_k_q);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign item_addr = addr_of(IDX_W'(row), IDX_W'(col));

	// index checks per command
	always_comb begin
		case (command)
			CMD_WRITE_A: item_ok = below(row, m_dim) && below(col, k_dim);
			CMD_WRITE_B: item_ok = below(row, k_dim) && below(col, n_dim);
			CMD_WRITE_C: item_ok = below(row, m_dim) && below(col, n_dim);
			CMD_COMPUTE: item_ok = 1'b1;
			CMD_READ_C:  item_ok = below(row, m_dim) && below(col, n_dim);
			default:     item_ok = 1'b0;
		endcase
	end

	assign a_we      = accept && (command == CMD_WRITE_A) && item_ok;
	assign b_we      = accept && (command == CMD_WRITE_B) && item_ok;
	assign c_item_we = accept && (command == CMD_WRITE_C) && item_ok;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q  <= 5'd16;
			cols_n_q  <= 5'd16;
			inner_k_q <= 5'd16;
			alpha_q   <= 16'sd256;
			beta_q    <= 16'sd0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROWS_M:  rows_m_q  <= cfg_data[4:0];
				REG_COLS_N:  cols_n_q  <= cfg_data[4:0];
				REG_INNER_K: inner_k_q <= cfg_data[4:0];
				REG_ALPHA:   alpha_q   <= $signed(cfg_data);
				REG_BETA:    beta_q    <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// loop ends for the m, n, k walk
	assign k_last = (CNT_W'(k_q) + CNT_W'(1)) == k_dim;
	assign n_last = (CNT_W'(n_q) + CNT_W'(1)) == n_dim;
	assign m_last = (CNT_W'(m_q) + CNT_W'(1)) == m_dim;

	// pipe empty after the last write-back of C
	assign drain_end = (state_q == S_DRAIN) && !op_s1.valid && !wb.busy;

	// sequencer: per C entry one beta slot, then one slot per k
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_q     <= '0;
			n_q     <= '0;
			k_q     <= '0;
			init_q  <= 1'b0;
			op_s1   <= '0;
		end else begin
			op_s1 <= '0;
			case (state_q)
				S_IDLE: begin
					if (accept && (command == CMD_COMPUTE)) begin
						state_q <= S_RUN;
						m_q     <= '0;
						n_q     <= '0;
						k_q     <= '0;
						init_q  <= 1'b1;
					end
				end
				S_RUN: begin
					op_s1.valid <= 1'b1;
					op_s1.init  <= init_q;
					op_s1.last  <= !init_q && k_last;
					if (init_q) begin
						init_q <= 1'b0;
						k_q    <= '0;
					end else if (k_last) begin
						init_q <= 1'b1;
						if (n_last) begin
							n_q <= '0;
							if (m_last) begin
								state_q <= S_DRAIN;
							end else begin
								m_q <= m_q + IDX_W'(1);
							end
						end else begin
							n_q <= n_q + IDX_W'(1);
						end
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					if (drain_end) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// C address follows its operation down the pipe
	always_ff @(posedge clk) begin
		caddr_s1 <= addr_of(m_q, n_q);
		caddr_s2 <= caddr_s1;
		caddr_s3 <= caddr_s2;
	end

	// A and B: item writes, compute reads
	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[item_addr] <= value[A_W-1:0];
		end
		a_s1 <= a_mem[addr_of(m_q, k_q)];
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_mem[item_addr] <= value[A_W-1:0];
		end
		b_s1 <= b_mem[addr_of(k_q, n_q)];
	end

	// C: item and write-back never overlap, the block is busy during compute
	// each entry is read for its beta slot and written once per compute, at distinct times
	assign c_we    = c_item_we || wb.we;
	assign c_waddr = wb.we ? caddr_s3 : item_addr;
	assign c_wdata = wb.we ? wb.data : value;
	assign c_raddr = (state_q == S_RUN) ? addr_of(m_q, n_q) : item_addr;

	always_ff @(posedge clk) begin
		if (c_we) begin
			c_mem[c_waddr] <= c_wdata;
		end
		c_s1 <= c_mem[c_raddr];
	end

	smma_mac_pipe u_mac_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.op_s1  (op_s1),
		.a_s1   (a_s1),
		.b_s1   (b_s1),
		.c_s1   (c_s1),
		.alpha  (alpha_q),
		.beta   (beta_q),
		.wb     (wb)
	);

	// one result beat per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			status_q <= 1'b0;
			rdsel_q  <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			rdsel_q <= 1'b0;
			if (accept && (command != CMD_COMPUTE)) begin
				done_q   <= 1'b1;
				status_q <= !item_ok;
				rdsel_q  <= (command == CMD_READ_C) && item_ok;
			end else if (drain_end) begin
				done_q   <= 1'b1;
				status_q <= 1'b0;
			end
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	// read data comes straight from the C memory output register
	assign read_value = rdsel_q ? c_s1 : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/smma_mac_pipe.sv
// multiply, scale and saturating accumulate pipe for the matrix engine
// depends on smma_pkg (op tag, write-back struct, sat32)
`timescale 1ns / 1ps
`default_nettype none

module smma_mac_pipe
	import smma_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire smma_op_t               op_s1,
	input  wire logic signed [A_W-1:0]  a_s1,
	input  wire logic signed [A_W-1:0]  b_s1,
	input  wire logic signed [C_W-1:0]  c_s1,
	input  wire logic signed [A_W-1:0]  alpha,
	input  wire logic signed [A_W-1:0]  beta,
	output smma_wb_t                    wb
);

	smma_op_t                  op_s2, op_s3;
	logic signed [C_W-1:0]     x_s2;
	logic signed [A_W-1:0]     y_s2;
	logic signed [PROD_W-1:0]  p_s3;
	logic signed [C_W-1:0]     acc_q;

	logic signed [C_W-1:0]     ab_prod;
	logic signed [PROD_W-8-1:0] shifted;
	logic signed [SUM_W-1:0]   base;
	logic signed [SUM_W-1:0]   sum;
	logic signed [C_W-1:0]     sat_val;

	// first product alpha*a, exact in 32 bits
	assign ab_prod = 32'(alpha) * 32'(a_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s2 <= '0;
			op_s3 <= '0;
		end else begin
			op_s2 <= op_s1;
			op_s3 <= op_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s2 <= op_s1.init ? c_s1 : ab_prod;
		y_s2 <= op_s1.init ? beta : b_s1;
		p_s3 <= 48'(x_s2) * 48'(y_s2);
		if (op_s3.valid) begin
			acc_q <= sat_val;
		end
	end

	// dropping the low byte is the floor shift
	assign shifted = $signed(p_s3[PROD_W-1:8]);
	assign base    = op_s3.init ? '0 : 41'(acc_q);
	assign sum     = base + 41'(shifted);
	assign sat_val = sat32(sum);

	assign wb.we   = op_s3.valid && op_s3.last;
	assign wb.busy = op_s2.valid || op_s3.valid;
	assign wb.data = sat_val;

endmodule

`default_nettype wire

FILE: hw/rtl/smma_checker.sv
// port-level assertions for the scaled matrix multiply-accumulate, bound to the top level
// depends on smma_pkg command codes and scaled_matrix_multiply_accumulate
`timescale 1ns / 1ps
`default_nettype none

module smma_checker
	import smma_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic [2:0]         command,
	input wire logic               done,
	input wire logic               status,
	input wire logic signed [31:0] read_value
);

	logic accept;
	assign accept = start && !busy;

	// read data only rides on a result beat
	a_rd_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> read_value == 32'sd0)
		else $error("read_value nonzero without done");

	// loads and reads answer in the next cycle
	a_short_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (command != CMD_COMPUTE) |=> done && !busy)
		else $error("single-cycle command gave no result beat");

	// compute raises busy with no early result
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (command == CMD_COMPUTE) |=> busy && !done)
		else $error("compute did not hold busy");

	// end of compute delivers its result with status zero
	a_compute_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done && !status && read_value == 32'sd0)
		else $error("compute ended without a clean result beat");

	// unknown commands are rejected
	a_bad_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (command > CMD_READ_C) |=> done && status)
		else $error("unknown command not flagged");

endmodule

bind scaled_matrix_multiply_accumulate smma_checker u_smma_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.command    (command),
	.done       (done),
	.status     (status),
	.read_value (read_value)
);

`default_nettype wire
